// ===== rtl/srec_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package srec_pkg;

   localparam int RATIO_BITS     = 48;
   localparam int FRAC_BITS      = 32;
   localparam int INT_BITS       = RATIO_BITS - FRAC_BITS;
   localparam int DIV_CNT_W      = 6;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_W    = 2;
   localparam int QUEUE_CNT_W    = QUEUE_PTR_W + 1;

   localparam logic [RATIO_BITS-1:0] TOLERANCE_RESET = 48'd429497;

   typedef enum logic [1:0] {
      VERDICT_PASS   = 2'd0,
      VERDICT_FAIL   = 2'd1,
      VERDICT_NO_REF = 2'd2
   } verdict_type;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_MAX_START,
      ST_MAX_WAIT,
      ST_AVG_START,
      ST_AVG_WAIT,
      ST_EMIT
   } back_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// ===== rtl/srec_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srec_front #(
   parameter int SAMPLE_BITS = 24
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire logic [SAMPLE_BITS-1:0] sample_ref,
   input  wire logic [SAMPLE_BITS-1:0] sample_test,
   input  wire logic                   last_pair,
   output logic                        push_valid,
   input  wire logic                   push_ready,
   output logic [SAMPLE_BITS:0]        push_diff,
   output logic [SAMPLE_BITS-1:0]      push_amp,
   output logic                        push_last
);

   logic                   valid_ff, valid_in;
   logic [SAMPLE_BITS:0]   diff_ff, diff_in;
   logic [SAMPLE_BITS-1:0] amp_ff, amp_in;
   logic                   last_ff;
   logic [SAMPLE_BITS:0]   delta;
   logic                   take;

   assign in_ready = !valid_ff || push_ready;
   assign take     = in_valid && in_ready;

   // classify: magnitude of the difference and of the reference
   always_comb begin
      delta   = {sample_ref[SAMPLE_BITS-1], sample_ref}
              - {sample_test[SAMPLE_BITS-1], sample_test};
      diff_in = delta[SAMPLE_BITS] ? (~delta + 1'b1) : delta;
      amp_in  = sample_ref[SAMPLE_BITS-1] ? (~sample_ref + 1'b1) : sample_ref;
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         diff_ff <= diff_in;
         amp_ff  <= amp_in;
         last_ff <= last_pair;
      end
   end

   assign push_valid = valid_ff;
   assign push_diff  = diff_ff;
   assign push_amp   = amp_ff;
   assign push_last  = last_ff;

endmodule

`default_nettype wire

// ===== rtl/srec_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srec_fifo #(
   parameter int WIDTH = 50
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_valid,
   output logic                  wr_ready,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  rd_valid,
   input  wire logic             rd_ready,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0]                 entry_ff [srec_pkg::QUEUE_DEPTH];
   logic [srec_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [srec_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [srec_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                             do_wr, do_rd;

   assign wr_ready = (count_ff != srec_pkg::QUEUE_CNT_W'(srec_pkg::QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;
   assign rd_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/srec_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srec_div #(
   parameter int NUM_W = 49,
   parameter int DEN_W = 48
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [NUM_W-1:0]                 num,
   input  wire logic [DEN_W-1:0]                 den,
   output logic [srec_pkg::RATIO_BITS-1:0]       quotient,
   output srec_pkg::div_status_type              status
);

   localparam int CMP_W = DEN_W + srec_pkg::INT_BITS + NUM_W;

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [srec_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DEN_W-1:0]                 den_ff, den_in;
   logic [DEN_W-1:0]                 rem_ff, rem_in;
   logic [srec_pkg::RATIO_BITS-1:0]  quo_ff, quo_in;
   logic [DEN_W:0]                   trial;
   logic [DEN_W:0]                   trial_sub;
   logic                             trial_ge;
   logic                             saturate;

   // ratio of 2^16 or more cannot be represented
   assign saturate = CMP_W'(num) >= CMP_W'({den, {srec_pkg::INT_BITS{1'b0}}});

   always_comb begin
      trial     = {rem_ff, quo_ff[srec_pkg::RATIO_BITS-1]};
      trial_sub = trial - {1'b0, den_ff};
      trial_ge  = trial >= {1'b0, den_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         den_in = den;
         if (saturate) begin
            quo_in  = '1;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            // integer part below den; shift in the low 16 bits, then 32 zeros
            rem_in  = DEN_W'(num >> srec_pkg::INT_BITS);
            quo_in  = {srec_pkg::INT_BITS'(num), {srec_pkg::FRAC_BITS{1'b0}}};
            cnt_in  = srec_pkg::DIV_CNT_W'(srec_pkg::RATIO_BITS - 1);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[srec_pkg::RATIO_BITS-2:0], trial_ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

// ===== rtl/srec_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srec_back #(
   parameter int SAMPLE_BITS      = 24,
   parameter int MAX_LOG2_SAMPLES = 24
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            q_valid,
   output logic                                 q_ready,
   input  wire logic [SAMPLE_BITS:0]            q_diff,
   input  wire logic [SAMPLE_BITS-1:0]          q_amp,
   input  wire logic                            q_last,
   input  wire logic [srec_pkg::RATIO_BITS-1:0] tolerance,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [srec_pkg::RATIO_BITS-1:0]      rsp_error,
   output srec_pkg::verdict_type                rsp_verdict
);

   localparam int DIFF_W = SAMPLE_BITS + 1;
   localparam int AMP_W  = SAMPLE_BITS;
   localparam int DTOT_W = SAMPLE_BITS + 1 + MAX_LOG2_SAMPLES;
   localparam int ATOT_W = SAMPLE_BITS + MAX_LOG2_SAMPLES;

   srec_pkg::back_state_type         state_ff, state_in;
   logic [DIFF_W-1:0]                pkdiff_ff, pkdiff_in;
   logic [DTOT_W-1:0]                dtot_ff, dtot_in;
   logic [AMP_W-1:0]                 pkamp_ff, pkamp_in;
   logic [ATOT_W-1:0]                atot_ff, atot_in;
   logic [srec_pkg::RATIO_BITS-1:0]  rmax_ff;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [srec_pkg::RATIO_BITS-1:0]  rsp_error_ff;
   srec_pkg::verdict_type            rsp_verdict_ff;
   logic [DTOT_W:0]                  dtot_sum;
   logic [ATOT_W:0]                  atot_sum;
   logic                             pop, div_start, sel_peak, emit, ref_zero;
   logic [DTOT_W-1:0]                div_num;
   logic [ATOT_W-1:0]                div_den;
   logic [srec_pkg::RATIO_BITS-1:0]  div_q;
   srec_pkg::div_status_type         div_status;
   logic [srec_pkg::RATIO_BITS-1:0]  err_val;
   srec_pkg::verdict_type            verdict_val;
   logic                             out_free;

   assign ref_zero = (atot_ff == '0);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srec_pkg::ST_ACCUM: begin
            if (q_valid && q_last) begin
               state_in = srec_pkg::ST_MAX_START;
            end
         end
         srec_pkg::ST_MAX_START: begin
            state_in = ref_zero ? srec_pkg::ST_EMIT : srec_pkg::ST_MAX_WAIT;
         end
         srec_pkg::ST_MAX_WAIT: begin
            if (div_status.done) begin
               state_in = srec_pkg::ST_AVG_START;
            end
         end
         srec_pkg::ST_AVG_START: begin
            state_in = srec_pkg::ST_AVG_WAIT;
         end
         srec_pkg::ST_AVG_WAIT: begin
            if (div_status.done) begin
               state_in = srec_pkg::ST_EMIT;
            end
         end
         srec_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = srec_pkg::ST_ACCUM;
            end
         end
         default: state_in = srec_pkg::ST_ACCUM;
      endcase
   end

   // state outputs
   always_comb begin
      pop       = 1'b0;
      div_start = 1'b0;
      sel_peak  = 1'b0;
      emit      = 1'b0;
      case (state_ff)
         srec_pkg::ST_ACCUM:     pop = q_valid;
         srec_pkg::ST_MAX_START: begin
            div_start = !ref_zero;
            sel_peak  = 1'b1;
         end
         srec_pkg::ST_MAX_WAIT:  sel_peak = 1'b1;
         srec_pkg::ST_AVG_START: div_start = 1'b1;
         srec_pkg::ST_AVG_WAIT:  sel_peak = 1'b0;
         srec_pkg::ST_EMIT:      emit = out_free;
         default:                pop = 1'b0;
      endcase
   end

   assign q_ready = pop;

   // saturating accumulation
   always_comb begin
      dtot_sum  = {1'b0, dtot_ff} + (DTOT_W + 1)'(q_diff);
      atot_sum  = {1'b0, atot_ff} + (ATOT_W + 1)'(q_amp);
      pkdiff_in = pkdiff_ff;
      dtot_in   = dtot_ff;
      pkamp_in  = pkamp_ff;
      atot_in   = atot_ff;
      if (emit) begin
         pkdiff_in = '0;
         dtot_in   = '0;
         pkamp_in  = '0;
         atot_in   = '0;
      end else if (pop) begin
         pkdiff_in = (q_diff > pkdiff_ff) ? q_diff : pkdiff_ff;
         pkamp_in  = (q_amp > pkamp_ff) ? q_amp : pkamp_ff;
         dtot_in   = dtot_sum[DTOT_W] ? '1 : dtot_sum[DTOT_W-1:0];
         atot_in   = atot_sum[ATOT_W] ? '1 : atot_sum[ATOT_W-1:0];
      end
   end

   assign div_num = sel_peak ? DTOT_W'(pkdiff_ff) : dtot_ff;
   assign div_den = sel_peak ? ATOT_W'(pkamp_ff) : atot_ff;

   srec_div #(
      .NUM_W (DTOT_W),
      .DEN_W (ATOT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .quotient (div_q),
      .status   (div_status)
   );

   always_comb begin
      if (ref_zero) begin
         err_val     = '0;
         verdict_val = srec_pkg::VERDICT_NO_REF;
      end else begin
         err_val     = (rmax_ff > div_q) ? rmax_ff : div_q;
         verdict_val = (err_val > tolerance) ? srec_pkg::VERDICT_FAIL
                                             : srec_pkg::VERDICT_PASS;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srec_pkg::ST_ACCUM;
         pkdiff_ff    <= '0;
         dtot_ff      <= '0;
         pkamp_ff     <= '0;
         atot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pkdiff_ff    <= pkdiff_in;
         dtot_ff      <= dtot_in;
         pkamp_ff     <= pkamp_in;
         atot_ff      <= atot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == srec_pkg::ST_MAX_WAIT && div_status.done) begin
         rmax_ff <= div_q;
      end
      if (emit) begin
         rsp_error_ff   <= err_val;
         rsp_verdict_ff <= verdict_val;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_error   = rsp_error_ff;
   assign rsp_verdict = rsp_verdict_ff;

`ifndef SYNTHESIS
   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      emit |=> (atot_ff == '0 && dtot_ff == '0 && pkamp_ff == '0 && pkdiff_ff == '0))
      else $error("accumulators not cleared after result");

   a_no_ref_zero_err: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_verdict_ff == srec_pkg::VERDICT_NO_REF) |-> rsp_error_ff == '0)
      else $error("all-zero reference with nonzero error");

   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      div_status.done |->
         (state_ff == srec_pkg::ST_MAX_WAIT || state_ff == srec_pkg::ST_AVG_WAIT))
      else $error("divider finished outside a wait state");

   a_total_covers_peak: assert property (@(posedge clock) disable iff (reset)
      ATOT_W'(pkamp_ff) <= atot_ff)
      else $error("amplitude total below peak amplitude");
`endif

endmodule

`default_nettype wire

// ===== rtl/stream_relative_error_check_top.sv =====
// A closing pair's result waits on two runs of the shared restoring divider, peak ratio
// then mean ratio, 48 steps each unless saturating; an all-zero reference skips both.
// Throughput: one pair per cycle until the queue fills; the back end stalls for one
// series' divisions and the front register plus a 4-entry queue absorb pairs meanwhile.
// Reset: synchronous, active high; clears accumulators, queue and handshakes and
// loads the tolerance register with 429497 (about 1e-4 in Q16.32).
`timescale 1ns / 1ps
`default_nettype none

module stream_relative_error_check_top #(
   parameter int SAMPLE_BITS      = 24,
   parameter int MAX_LOG2_SAMPLES = 24
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_tvalid,
   output logic                                          req_tready,
   // sample_ref, sample_test
   input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       req_tdata,
   // last_pair
   input  wire logic                                     req_tlast,
   output logic                                          rsp_tvalid,
   input  wire logic                                     rsp_tready,
   // relative_error
   output logic [srec_pkg::RATIO_BITS-1:0]               rsp_tdata,
   // verdict
   output logic [1:0]                                    rsp_tuser,
   input  wire logic                                     csr_wr_en,
   input  wire logic [srec_pkg::RATIO_BITS-1:0]          csr_wr_data
);

   localparam int ENTRY_W = 2 * SAMPLE_BITS + 2;

   logic [srec_pkg::RATIO_BITS-1:0] tolerance_ff;
   logic                            push_valid, push_ready, push_last;
   logic [SAMPLE_BITS:0]            push_diff;
   logic [SAMPLE_BITS-1:0]          push_amp;
   logic                            q_valid, q_ready;
   logic [ENTRY_W-1:0]              q_data;
   srec_pkg::verdict_type           verdict;

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= srec_pkg::TOLERANCE_RESET;
      end else if (csr_wr_en) begin
         tolerance_ff <= csr_wr_data;
      end
   end

   srec_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .sample_ref  (req_tdata[SAMPLE_BITS-1:0]),
      .sample_test (req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .last_pair   (req_tlast),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_diff   (push_diff),
      .push_amp    (push_amp),
      .push_last   (push_last)
   );

   srec_fifo #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .wr_data  ({push_last, push_amp, push_diff}),
      .rd_valid (q_valid),
      .rd_ready (q_ready),
      .rd_data  (q_data)
   );

   srec_back #(
      .SAMPLE_BITS      (SAMPLE_BITS),
      .MAX_LOG2_SAMPLES (MAX_LOG2_SAMPLES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_diff      (q_data[SAMPLE_BITS:0]),
      .q_amp       (q_data[2*SAMPLE_BITS:SAMPLE_BITS+1]),
      .q_last      (q_data[ENTRY_W-1]),
      .tolerance   (tolerance_ff),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_error   (rsp_tdata),
      .rsp_verdict (verdict)
   );

   assign rsp_tuser = verdict;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int          DRAIN_CYCLES = 150;
   localparam int          STALL_LIMIT  = 5000;
   localparam int          LONG_HOLD    = 600;
   localparam int          ITEM_TARGET  = 1500;
   localparam int          QUIET_FROM   = 1300;
   localparam logic [23:0] S_MIN        = 24'h800000;
   localparam logic [23:0] S_MAX        = 24'h7fffff;
   localparam logic [47:0] RATIO_ONE    = 48'h0001_0000_0000;

   typedef struct packed {
      logic [srec_pkg::RATIO_BITS-1:0] ratio;
      srec_pkg::verdict_type           verdict;
   } ratio_result_type;

   typedef struct packed {
      logic                            tol_wr;
      logic [srec_pkg::RATIO_BITS-1:0] tol;
      logic [23:0]                     ref_smp;
      logic [23:0]                     test_smp;
      logic                            last;
      logic                            typed;
      ratio_result_type                want;
   } pair_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_tvalid;
   logic                            req_tready;
   logic [47:0]                     req_tdata;
   logic                            req_tlast;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [srec_pkg::RATIO_BITS-1:0] rsp_tdata;
   logic [1:0]                      rsp_tuser;
   logic                            csr_wr_en;
   logic [srec_pkg::RATIO_BITS-1:0] csr_wr_data;

   // predictor state
   logic [24:0]                     peak_diff_q;
   logic [48:0]                     diff_sum_q;
   logic [23:0]                     peak_amp_q;
   logic [47:0]                     amp_sum_q;
   logic [srec_pkg::RATIO_BITS-1:0] tolerance_q;

   ratio_result_type ratios_due[$];
   pair_row_type     directed_rows[$];
   int               error_count  = 0;
   int               items_sent   = 0;
   int               quiet_cycles = 0;
   logic             pace_gaps    = 1'b1;
   logic             quiet_tail   = 1'b0;
   logic             hold_request = 1'b0;

   always #1 clock = ~clock;

   stream_relative_error_check_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   function automatic logic [srec_pkg::RATIO_BITS-1:0] ratio_q16_32(
         input logic [48:0] num, input logic [47:0] den);
      logic [80:0] quot;
      quot = {num, 32'd0} / {33'd0, den};
      return (|quot[80:48]) ? '1 : quot[47:0];
   endfunction

   // Accumulate one pair; on the closing pair produce the ratio and clear the run.
   function automatic void fold_pair(input logic [23:0] ref_smp, input logic [23:0] test_smp,
                                     input logic last, output logic fired,
                                     output ratio_result_type res);
      int                              a;
      int                              b;
      int                              d;
      logic [24:0]                     diff;
      logic [23:0]                     amp;
      logic [49:0]                     dsum;
      logic [48:0]                     asum;
      logic [srec_pkg::RATIO_BITS-1:0] r_peak;
      logic [srec_pkg::RATIO_BITS-1:0] r_mean;
      a = int'($signed(ref_smp));
      b = int'($signed(test_smp));
      d = a - b;
      diff = 25'(d < 0 ? -d : d);
      amp  = 24'(a < 0 ? -a : a);
      if (diff > peak_diff_q) peak_diff_q = diff;
      if (amp > peak_amp_q) peak_amp_q = amp;
      dsum = {1'b0, diff_sum_q} + {25'd0, diff};
      diff_sum_q = dsum[49] ? '1 : dsum[48:0];
      asum = {1'b0, amp_sum_q} + {25'd0, amp};
      amp_sum_q = asum[48] ? '1 : asum[47:0];
      fired = last;
      res = '0;
      if (!last) return;
      if (amp_sum_q == '0) begin
         res.ratio   = '0;
         res.verdict = srec_pkg::VERDICT_NO_REF;
      end else begin
         r_peak = ratio_q16_32({24'd0, peak_diff_q}, {24'd0, peak_amp_q});
         r_mean = ratio_q16_32(diff_sum_q, amp_sum_q);
         res.ratio   = (r_peak > r_mean) ? r_peak : r_mean;
         res.verdict = (res.ratio > tolerance_q) ? srec_pkg::VERDICT_FAIL
                                                 : srec_pkg::VERDICT_PASS;
      end
      peak_diff_q = '0;
      diff_sum_q  = '0;
      peak_amp_q  = '0;
      amp_sum_q   = '0;
   endfunction

   function automatic void add_row(input logic tol_wr,
                                   input logic [srec_pkg::RATIO_BITS-1:0] tol,
                                   input logic [23:0] ref_smp, input logic [23:0] test_smp,
                                   input logic last, input logic typed,
                                   input logic [srec_pkg::RATIO_BITS-1:0] ratio,
                                   input srec_pkg::verdict_type v);
      pair_row_type row;
      row.tol_wr       = tol_wr;
      row.tol          = tol;
      row.ref_smp      = ref_smp;
      row.test_smp     = test_smp;
      row.last         = last;
      row.typed        = typed;
      row.want.ratio   = ratio;
      row.want.verdict = v;
      directed_rows.push_back(row);
   endfunction

   function automatic logic [23:0] scaled_sample(input int min_shift);
      logic signed [23:0] v;
      v = 24'($urandom);
      return v >>> $urandom_range(min_shift, 23);
   endfunction

   function automatic logic [23:0] extreme_sample();
      case ($urandom_range(0, 5))
         0: return S_MIN;
         1: return S_MAX;
         2: return 24'd0;
         3: return 24'd1;
         4: return 24'hffffff;
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string what,
                                  input logic [srec_pkg::RATIO_BITS-1:0] got,
                                  input logic [srec_pkg::RATIO_BITS-1:0] want);
      $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic send_pair(input logic [23:0] ref_smp, input logic [23:0] test_smp,
                            input logic last, input logic typed,
                            input ratio_result_type typed_want);
      logic             fired;
      ratio_result_type predicted;
      if (pace_gaps && !quiet_tail && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {test_smp, ref_smp};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      fold_pair(ref_smp, test_smp, last, fired, predicted);
      if (fired) ratios_due.push_back(typed ? typed_want : predicted);
   endtask

   // Change the tolerance only once the block has gone idle.
   task automatic write_tolerance(input logic [srec_pkg::RATIO_BITS-1:0] value);
      req_tvalid <= 1'b0;
      while (ratios_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      tolerance_q = value;
   endtask

   task automatic send_series();
      int          len;
      int          kind;
      logic [23:0] r;
      logic [23:0] t;
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
      kind = $urandom_range(0, 9);
      for (int i = 0; i < len; i++) begin
         case (kind)
            0: begin
               r = 24'($urandom);
               t = 24'($urandom);
            end
            6: begin
               r = '0;
               t = 24'($urandom);
            end
            7: begin
               r = scaled_sample(0);
               t = r;
            end
            8: begin
               r = extreme_sample();
               t = extreme_sample();
            end
            9: begin
               r = scaled_sample(0);
               t = scaled_sample(0);
            end
            default: begin
               r = scaled_sample(0);
               t = r + scaled_sample(6);
            end
         endcase
         send_pair(r, t, i == len - 1, 1'b0, '0);
      end
   endtask

   initial begin : stimulus
      logic [63:0]                     wide;
      logic [srec_pkg::RATIO_BITS-1:0] tol;
      int                              phase;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      tolerance_q = srec_pkg::TOLERANCE_RESET;
      peak_diff_q = '0;
      diff_sum_q  = '0;
      peak_amp_q  = '0;
      amp_sum_q   = '0;

      add_row(0, '0, 24'd0, 24'd0, 1, 1, '0, srec_pkg::VERDICT_NO_REF);
      add_row(0, '0, S_MAX, S_MAX, 1, 1, '0, srec_pkg::VERDICT_PASS);
      add_row(0, '0, S_MIN, S_MAX, 1, 1, 48'd8589934080, srec_pkg::VERDICT_FAIL);
      add_row(0, '0, 24'd1, S_MIN, 1, 1, '1, srec_pkg::VERDICT_FAIL);
      add_row(0, '0, 24'd1, 24'd0, 1, 1, RATIO_ONE, srec_pkg::VERDICT_FAIL);
      add_row(0, '0, 24'd0, 24'd5, 0, 0, '0, srec_pkg::VERDICT_PASS);
      add_row(0, '0, 24'd0, S_MIN, 0, 0, '0, srec_pkg::VERDICT_PASS);
      add_row(0, '0, 24'd0, S_MAX, 1, 1, '0, srec_pkg::VERDICT_NO_REF);
      add_row(0, '0, S_MAX, 24'h7ffffe, 1, 0, '0, srec_pkg::VERDICT_PASS);
      add_row(0, '0, S_MIN, S_MIN, 0, 0, '0, srec_pkg::VERDICT_PASS);
      add_row(0, '0, 24'hffffff, 24'd0, 0, 0, '0, srec_pkg::VERDICT_PASS);
      add_row(0, '0, 24'd100, 24'd101, 1, 0, '0, srec_pkg::VERDICT_PASS);
      // peak ratio dominates
      add_row(0, '0, 24'd1000, 24'd1000, 0, 0, '0, srec_pkg::VERDICT_PASS);
      add_row(0, '0, 24'd1000, 24'd1000, 0, 0, '0, srec_pkg::VERDICT_PASS);
      add_row(0, '0, 24'd10, 24'd20, 1, 0, '0, srec_pkg::VERDICT_PASS);
      // mean ratio dominates
      add_row(0, '0, 24'd1000, 24'd1010, 0, 0, '0, srec_pkg::VERDICT_PASS);
      add_row(0, '0, 24'd10, 24'd20, 1, 0, '0, srec_pkg::VERDICT_PASS);
      // ratio equal to the tolerance still passes
      add_row(1, RATIO_ONE, 24'd1, 24'd0, 1, 1, RATIO_ONE, srec_pkg::VERDICT_PASS);
      add_row(0, '0, 24'd1, 24'hffffff, 1, 1, 48'h0002_0000_0000, srec_pkg::VERDICT_FAIL);
      add_row(1, '0, 24'd5, 24'd5, 1, 1, '0, srec_pkg::VERDICT_PASS);
      add_row(0, '0, S_MAX, 24'h7ffffe, 1, 0, '0, srec_pkg::VERDICT_PASS);
      add_row(1, '1, 24'd1, S_MIN, 1, 1, '1, srec_pkg::VERDICT_PASS);
      add_row(0, '0, S_MIN, 24'd0, 1, 0, '0, srec_pkg::VERDICT_PASS);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].tol_wr) write_tolerance(directed_rows[i].tol);
         send_pair(directed_rows[i].ref_smp, directed_rows[i].test_smp,
                   directed_rows[i].last, directed_rows[i].typed, directed_rows[i].want);
      end

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         case (phase % 6)
            0: tol = srec_pkg::TOLERANCE_RESET;
            1: tol = '0;
            2: tol = '1;
            3: tol = 48'd1 << $urandom_range(16, 40);
            4: begin
               wide = {$urandom, $urandom};
               tol  = wide[47:0];
            end
            default: tol = RATIO_ONE >> $urandom_range(0, 24);
         endcase
         write_tolerance(tol);
         quiet_tail = (items_sent >= QUIET_FROM);
         pace_gaps  = ($urandom_range(0, 3) != 0);
         // stall the result side long enough for the input side to back up
         if (phase == 2) hold_request = 1'b1;
         while (items_sent < ITEM_TARGET && items_sent < 120 * (phase + 1) + 60)
            send_series();
         phase++;
      end

      req_tvalid <= 1'b0;
      while (ratios_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   initial begin : result_pacing
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : result_check
      ratio_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (ratios_due.size() == 0) begin
            report_mismatch("result beat with nothing pending", rsp_tdata, '0);
         end else begin
            want = ratios_due.pop_front();
            if (rsp_tdata !== want.ratio)
               report_mismatch("relative_error", rsp_tdata, want.ratio);
            if (rsp_tuser !== 2'(want.verdict))
               report_mismatch("verdict", 48'(rsp_tuser), 48'(want.verdict));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

endmodule
